/* rtl/core/rfci_pkg.sv */
// ----------------------------------------------------------------------------
// rfci_pkg
// Shared types, codes and helpers for the ray / finite cylinder test unit.
// ----------------------------------------------------------------------------
package rfci_pkg;

  localparam int SAT_W = 72;
  localparam int QUEUE_DEPTH = 4;

  // result codes
  localparam logic [2:0] OUT_HIT      = 3'd0;
  localparam logic [2:0] OUT_NO_ROOT  = 3'd1;
  localparam logic [2:0] OUT_MISS     = 3'd2;
  localparam logic [2:0] OUT_CUT      = 3'd3;
  localparam logic [2:0] OUT_PARALLEL = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_CENTRE_X  = 3'd0;
  localparam logic [2:0] REG_CENTRE_Y  = 3'd1;
  localparam logic [2:0] REG_CENTRE_Z  = 3'd2;
  localparam logic [2:0] REG_AXIS_X    = 3'd3;
  localparam logic [2:0] REG_AXIS_Y    = 3'd4;
  localparam logic [2:0] REG_AXIS_Z    = 3'd5;
  localparam logic [2:0] REG_RADIUS_SQ = 3'd6;

  localparam logic signed [31:0] PARALLEL_EPS = 32'sd4;

  localparam logic signed [SAT_W-1:0] S32_MAX = 72'sd2147483647;
  localparam logic signed [SAT_W-1:0] S32_MIN = -72'sd2147483648;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        current_dist;
    logic [30:0]        range_min;
    logic [30:0]        range_max;
    logic signed [31:0] cut_low;
    logic signed [31:0] cut_high;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        new_dist;
    logic signed [31:0] axial_pos;
    logic [2:0]         outcome;
  } result_t;

  typedef struct packed {
    logic [2:0][31:0] centre;
    logic [2:0][17:0] axis;
    logic [30:0]      radius_sq;
  } cfg_t;

  // what the back end needs of a ray once it is classified
  typedef struct packed {
    logic [2:0]         code;
    logic [2:0][31:0]   d;
    logic [2:0][32:0]   oc;
    logic [30:0]        cur;
    logic [30:0]        rmin;
    logic [30:0]        rmax;
    logic signed [31:0] cutl;
    logic signed [31:0] cuth;
  } carry_t;

  typedef struct packed {
    carry_t             carry;
    logic [63:0]        disc;
    logic signed [31:0] h;
    logic signed [31:0] a;
  } qitem_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > S32_MAX) begin
      return 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

/* rtl/core/ray_finite_cylinder_intersect_unit.sv */
// ----------------------------------------------------------------------------
// ray_finite_cylinder_intersect_unit
// Tests rays against one configured cylinder clipped along its axis (Q16.16).
// ----------------------------------------------------------------------------
//
//  channel   signals                               transaction taken when
//  -------   -----------------------------------   -------------------------
//  ray in    start, busy, ray                      start && !busy at clk edge
//  result    done, result                          edge ending the done cycle
//  config    cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//            cfg_data
//
//  One ray per cycle, sustained. A taken ray passes the front pipe, the queue,
//  the 32-stage square root, the (34 + FRAC_BITS)-stage root divider and the
//  hit-point registers before its result strobes.
//  rst is synchronous; it empties the pipes and loads the reset cylinder:
//  centre at the origin, axis +y, radius_sq 1.0.
//  The result side cannot stall. busy only rises if the queue between the
//  front and back halves fills, which the back half never lets happen.
//  cfg_ready is always high; write configuration only while no ray is in
//  flight.
//
module ray_finite_cylinder_intersect_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rfci_pkg::ray_t    ray,
  output logic              done,
  output rfci_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import rfci_pkg::*;

  cfg_t   cfg;
  logic   q_push;
  logic   q_pop;
  logic   q_empty;
  logic   q_full;
  qitem_t q_in;
  qitem_t q_out;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre    <= '0;
      cfg.axis[0]   <= 18'sd0;
      cfg.axis[1]   <= 18'sd65536;
      cfg.axis[2]   <= 18'sd0;
      cfg.radius_sq <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTRE_X:  cfg.centre[0]  <= cfg_data;
        REG_CENTRE_Y:  cfg.centre[1]  <= cfg_data;
        REG_CENTRE_Z:  cfg.centre[2]  <= cfg_data;
        REG_AXIS_X:    cfg.axis[0]    <= cfg_data[17:0];
        REG_AXIS_Y:    cfg.axis[1]    <= cfg_data[17:0];
        REG_AXIS_Z:    cfg.axis[2]    <= cfg_data[17:0];
        REG_RADIUS_SQ: cfg.radius_sq  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // front: coefficients and early outcomes (parallel, no real root)
  rfci_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .ray    (ray),
    .cfg    (cfg),
    .q_full (q_full),
    .q_pop  (q_pop),
    .push   (q_push),
    .item   (q_in)
  );

  rfci_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .pop      (q_pop),
    .item_out (q_out),
    .empty    (q_empty),
    .full     (q_full)
  );

  // the back half never stalls: take the head whenever there is one
  assign q_pop = !q_empty;

  rfci_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_pop),
    .item       (q_out),
    .cfg        (cfg),
    .done       (done),
    .result     (result)
  );

  // queue never overflows
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_push && !q_pop))
    else $error("queue overflow");

  // hit flag and outcome code agree
  a_hit_matches_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.hit == (result.outcome == OUT_HIT)))
    else $error("hit flag disagrees with outcome");

  // no axial position reported when no root was picked
  a_axial_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.outcome == OUT_PARALLEL || result.outcome == OUT_NO_ROOT
              || result.outcome == OUT_MISS)) |-> (result.axial_pos == 32'sd0))
    else $error("axial position set without chosen root");

  // front never stalls since the back half drains every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("front end stalled");

endmodule

/* rtl/core/rfci_queue.sv */
// ----------------------------------------------------------------------------
// rfci_queue
// Short FIFO between the classifying front end and the solving back end.
// ----------------------------------------------------------------------------
module rfci_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rfci_pkg::qitem_t item_in,
  input  logic            pop,
  output rfci_pkg::qitem_t item_out,
  output logic            empty,
  output logic            full
);
  import rfci_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qitem_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign item_out = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= item_in;
    end
  end

endmodule

/* rtl/core/rfci_front.sv */
// ----------------------------------------------------------------------------
// rfci_front
// Dot products, quadratic coefficients and discriminant; tags parallel rays
// and negative discriminants before they reach the solver.
// ----------------------------------------------------------------------------
module rfci_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rfci_pkg::ray_t   ray,
  input  rfci_pkg::cfg_t   cfg,
  input  logic             q_full,
  input  logic             q_pop,
  output logic             push,
  output rfci_pkg::qitem_t item
);
  import rfci_pkg::*;

  typedef struct packed {
    logic [30:0]        cur;
    logic [30:0]        rmin;
    logic [30:0]        rmax;
    logic signed [31:0] cutl;
    logic signed [31:0] cuth;
  } side_t;

  logic adv;
  logic accept;
  logic v0, v1, v2, v3, v4, v5;

  // stage 0
  logic signed [31:0] d0 [3];
  logic signed [32:0] oc0 [3];
  side_t              sd0;
  // stage 1
  logic [31:0]        dmag [3];
  logic [31:0]        ocmag [3];
  logic [63:0]        pdd [3];
  logic signed [49:0] pdu [3];
  logic signed [64:0] pod [3];
  logic signed [50:0] pou [3];
  logic [63:0]        poo [3];
  logic signed [31:0] d1 [3];
  logic signed [32:0] oc1 [3];
  side_t              sd1;
  // stage 2
  logic signed [31:0] dd2, du2, od2, ou2, oo2;
  logic signed [31:0] d2 [3];
  logic signed [32:0] oc2 [3];
  side_t              sd2;
  // stage 3
  logic signed [63:0] pduu, pduo, pouu;
  logic signed [31:0] dd3, od3, oo3;
  logic signed [31:0] d3 [3];
  logic signed [32:0] oc3 [3];
  side_t              sd3;
  // stage 4
  logic signed [31:0] a4, h4, c4;
  logic signed [31:0] d4 [3];
  logic signed [32:0] oc4 [3];
  side_t              sd4;
  // stage 5
  logic signed [63:0] hh5, ac5;
  logic signed [31:0] a5, h5;
  logic signed [31:0] d5 [3];
  logic signed [32:0] oc5 [3];
  side_t              sd5;
  logic signed [64:0] diff;

  // the back end drains the queue every cycle it holds something
  assign adv    = !(q_full && !q_pop);
  assign busy   = !adv;
  assign accept = start && adv;
  assign push   = v5 && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i]  = d0[i][31] ? 32'(-d0[i]) : 32'(d0[i]);
      ocmag[i] = oc0[i][32] ? 32'(-oc0[i]) : 32'(oc0[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0[0]  <= ray.dir_x;
      d0[1]  <= ray.dir_y;
      d0[2]  <= ray.dir_z;
      oc0[0] <= 33'(ray.origin_x) - 33'($signed(cfg.centre[0]));
      oc0[1] <= 33'(ray.origin_y) - 33'($signed(cfg.centre[1]));
      oc0[2] <= 33'(ray.origin_z) - 33'($signed(cfg.centre[2]));
      sd0    <= '{cur: ray.current_dist, rmin: ray.range_min, rmax: ray.range_max,
                  cutl: ray.cut_low, cuth: ray.cut_high};

      for (int i = 0; i < 3; i++) begin
        pdd[i] <= 64'(dmag[i]) * 64'(dmag[i]);
        pdu[i] <= d0[i] * $signed(cfg.axis[i]);
        pod[i] <= d0[i] * oc0[i];
        pou[i] <= oc0[i] * $signed(cfg.axis[i]);
        poo[i] <= 64'(ocmag[i]) * 64'(ocmag[i]);
      end
      d1  <= d0;
      oc1 <= oc0;
      sd1 <= sd0;

      dd2 <= sat32($signed({8'b0, pdd[0] >> FRAC_BITS}) + $signed({8'b0, pdd[1] >> FRAC_BITS})
                   + $signed({8'b0, pdd[2] >> FRAC_BITS}));
      du2 <= sat32(72'(pdu[0] >>> FRAC_BITS) + 72'(pdu[1] >>> FRAC_BITS)
                   + 72'(pdu[2] >>> FRAC_BITS));
      od2 <= sat32(72'(pod[0] >>> FRAC_BITS) + 72'(pod[1] >>> FRAC_BITS)
                   + 72'(pod[2] >>> FRAC_BITS));
      ou2 <= sat32(72'(pou[0] >>> FRAC_BITS) + 72'(pou[1] >>> FRAC_BITS)
                   + 72'(pou[2] >>> FRAC_BITS));
      oo2 <= sat32($signed({8'b0, poo[0] >> FRAC_BITS}) + $signed({8'b0, poo[1] >> FRAC_BITS})
                   + $signed({8'b0, poo[2] >> FRAC_BITS}));
      d2  <= d1;
      oc2 <= oc1;
      sd2 <= sd1;

      pduu <= du2 * du2;
      pduo <= du2 * ou2;
      pouu <= ou2 * ou2;
      dd3  <= dd2;
      od3  <= od2;
      oo3  <= oo2;
      d3   <= d2;
      oc3  <= oc2;
      sd3  <= sd2;

      a4  <= sat32(72'(dd3) - 72'(pduu >>> FRAC_BITS));
      h4  <= sat32(72'(od3) - 72'(pduo >>> FRAC_BITS));
      c4  <= sat32(72'(oo3) - 72'(pouu >>> FRAC_BITS) - 72'($signed({1'b0, cfg.radius_sq})));
      d4  <= d3;
      oc4 <= oc3;
      sd4 <= sd3;

      hh5 <= h4 * h4;
      ac5 <= a4 * c4;
      a5  <= a4;
      h5  <= h4;
      d5  <= d4;
      oc5 <= oc4;
      sd5 <= sd4;
    end
  end

  // discriminant (quarter form), clamped to the int64 maximum
  assign diff = 65'(hh5) - 65'(ac5);

  always_comb begin
    item            = '0;
    item.h          = h5;
    item.a          = a5;
    item.disc       = (diff > 65'sh0_7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff
                                                          : diff[63:0];
    item.carry.cur  = sd5.cur;
    item.carry.rmin = sd5.rmin;
    item.carry.rmax = sd5.rmax;
    item.carry.cutl = sd5.cutl;
    item.carry.cuth = sd5.cuth;
    for (int i = 0; i < 3; i++) begin
      item.carry.d[i]  = d5[i];
      item.carry.oc[i] = oc5[i];
    end
    if (a5 <= PARALLEL_EPS) begin
      item.carry.code = OUT_PARALLEL;
    end else if (diff[64]) begin
      item.carry.code = OUT_NO_ROOT;
    end else begin
      item.carry.code = OUT_HIT;
    end
  end

endmodule

/* rtl/core/rfci_isqrt.sv */
// ----------------------------------------------------------------------------
// rfci_isqrt
// Floored 64-bit integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module rfci_isqrt #(
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [63:0]      radicand,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [31:0]      root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int STEPS = 32;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] rt;
  } sq_st_t;

  sq_st_t           st [STEPS];
  logic             vld [STEPS];
  logic [TAG_W-1:0] tg [STEPS];
  sq_st_t           st_in;

  function automatic sq_st_t sq_step(input sq_st_t s, input logic [63:0] b);
    sq_st_t      n;
    logic [63:0] trial;
    trial = s.rt + b;
    if (s.rem >= trial) begin
      n.rem = s.rem - trial;
      n.rt  = (s.rt >> 1) + b;
    end else begin
      n.rem = s.rem;
      n.rt  = s.rt >> 1;
    end
    return n;
  endfunction

  assign st_in = '{rem: radicand, rt: 64'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STEPS; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int k = 1; k < STEPS; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= sq_step(st_in, 64'd1 << (2 * (STEPS - 1)));
    tg[0] <= in_tag;
    for (int k = 1; k < STEPS; k++) begin
      st[k] <= sq_step(st[k-1], 64'd1 << (2 * (STEPS - 1 - k)));
      tg[k] <= tg[k-1];
    end
  end

  assign out_valid = vld[STEPS-1];
  assign root      = st[STEPS-1].rt[31:0];
  assign out_tag   = tg[STEPS-1];

endmodule

/* rtl/core/rfci_div.sv */
// ----------------------------------------------------------------------------
// rfci_div
// Two-lane restoring divider with a shared divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rfci_div #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 31,
  parameter int TAG_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0][NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0]      divisor,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_valid,
  output logic [1:0][NUM_W-1:0] quotient,
  output logic [TAG_W-1:0]      out_tag
);

  // dq shifts the dividend out at the top and the quotient in at the bottom
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] dq;
  } lane_t;

  lane_t            ln [NUM_W][2];
  logic [DEN_W-1:0] den [NUM_W];
  logic             vld [NUM_W];
  logic [TAG_W-1:0] tg [NUM_W];

  function automatic lane_t div_step(input lane_t s, input logic [DEN_W-1:0] dv);
    lane_t        n;
    logic [DEN_W:0] r;
    logic         qb;
    r  = {s.rem, s.dq[NUM_W-1]};
    qb = (r >= {1'b0, dv});
    n.rem = qb ? DEN_W'(r - {1'b0, dv}) : r[DEN_W-1:0];
    n.dq  = {s.dq[NUM_W-2:0], qb};
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_W; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int k = 1; k < NUM_W; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    den[0] <= divisor;
    tg[0]  <= in_tag;
    for (int j = 0; j < 2; j++) begin
      ln[0][j] <= div_step('{rem: '0, dq: dividend[j]}, divisor);
    end
    for (int k = 1; k < NUM_W; k++) begin
      den[k] <= den[k-1];
      tg[k]  <= tg[k-1];
      for (int j = 0; j < 2; j++) begin
        ln[k][j] <= div_step(ln[k-1][j], den[k-1]);
      end
    end
  end

  assign out_valid   = vld[NUM_W-1];
  assign quotient[0] = ln[NUM_W-1][0].dq;
  assign quotient[1] = ln[NUM_W-1][1].dq;
  assign out_tag     = tg[NUM_W-1];

endmodule

/* rtl/core/rfci_back.sv */
// ----------------------------------------------------------------------------
// rfci_back
// Root extraction, root choice, hit point and axial clip for queued rays.
// ----------------------------------------------------------------------------
module rfci_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  rfci_pkg::qitem_t  item,
  input  rfci_pkg::cfg_t    cfg,
  output logic              done,
  output rfci_pkg::result_t result
);
  import rfci_pkg::*;

  localparam int NUM_W = 34 + FRAC_BITS;

  typedef struct packed {
    carry_t             carry;
    logic signed [31:0] h;
    logic signed [31:0] a;
  } sq_tag_t;

  typedef struct packed {
    carry_t carry;
    logic   neg0;
    logic   neg1;
  } dv_tag_t;

  localparam int SQ_TAG_W = $bits(sq_tag_t);
  localparam int DV_TAG_W = $bits(dv_tag_t);

  // root
  logic        sq_vld;
  logic [31:0] sq_root;
  sq_tag_t     sq_tag;
  logic [SQ_TAG_W-1:0] sq_tag_bits;

  // numerators
  logic signed [33:0] hs, ss, num0, num1;
  logic               nv;
  logic [1:0][NUM_W-1:0] nmag;
  logic [30:0]        nden;
  dv_tag_t            ntag;

  // division
  logic                  dv_vld;
  logic [1:0][NUM_W-1:0] dv_q;
  logic [DV_TAG_W-1:0]   dv_tag_bits;
  dv_tag_t               dv_tag;

  // root choice
  logic signed [NUM_W:0] t0s, t1s, rmin_s, rmax_s, cur_s, tpick;
  logic                  in0, in1;
  logic [2:0]            code_pick;
  logic                  vs;
  logic [2:0]            code_s;
  logic [30:0]           ts;
  carry_t                cs;

  // hit point
  logic                  vp;
  logic signed [63:0]    prod [3];
  logic [2:0]            code_p;
  logic [30:0]           tp;
  carry_t                cp;
  logic                  va;
  logic signed [31:0]    hp [3];
  logic [2:0]            code_a;
  logic [30:0]           ta;
  carry_t                ca;
  logic                  vm;
  logic signed [49:0]    pm [3];
  logic [2:0]            code_m;
  logic [30:0]           tm;
  carry_t                cm;
  logic signed [31:0]    mpos;
  logic [2:0]            code_f;

  rfci_isqrt #(
    .TAG_W (SQ_TAG_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .radicand  (item.disc),
    .in_tag    (SQ_TAG_W'({item.carry, item.h, item.a})),
    .out_valid (sq_vld),
    .root      (sq_root),
    .out_tag   (sq_tag_bits)
  );

  assign sq_tag = sq_tag_t'(sq_tag_bits);
  assign hs     = 34'(sq_tag.h);
  assign ss     = $signed({2'b0, sq_root});
  assign num1   = -hs - ss;
  assign num0   = -hs + ss;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= 1'b0;
      vs <= 1'b0;
      vp <= 1'b0;
      va <= 1'b0;
      vm <= 1'b0;
      done <= 1'b0;
    end else begin
      nv <= sq_vld;
      vs <= dv_vld;
      vp <= vs;
      va <= vp;
      vm <= va;
      done <= vm;
    end
  end

  always_ff @(posedge clk) begin
    nmag[0]   <= {(num0[33] ? 34'(-num0) : 34'(num0)), {FRAC_BITS{1'b0}}};
    nmag[1]   <= {(num1[33] ? 34'(-num1) : 34'(num1)), {FRAC_BITS{1'b0}}};
    nden      <= sq_tag.a[30:0];
    ntag      <= '{carry: sq_tag.carry, neg0: num0[33], neg1: num1[33]};
  end

  rfci_div #(
    .NUM_W (NUM_W),
    .DEN_W (31),
    .TAG_W (DV_TAG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nv),
    .dividend  (nmag),
    .divisor   (nden),
    .in_tag    (DV_TAG_W'(ntag)),
    .out_valid (dv_vld),
    .quotient  (dv_q),
    .out_tag   (dv_tag_bits)
  );

  assign dv_tag = dv_tag_t'(dv_tag_bits);

  always_comb begin
    t0s    = $signed({1'b0, dv_q[0]});
    t1s    = $signed({1'b0, dv_q[1]});
    if (dv_tag.neg0) begin
      t0s = -t0s;
    end
    if (dv_tag.neg1) begin
      t1s = -t1s;
    end
    rmin_s = $signed((NUM_W+1)'(dv_tag.carry.rmin));
    rmax_s = $signed((NUM_W+1)'(dv_tag.carry.rmax));
    cur_s  = $signed((NUM_W+1)'(dv_tag.carry.cur));
    in1    = (t1s >= rmin_s) && (t1s <= rmax_s);
    in0    = (t0s >= rmin_s) && (t0s <= rmax_s);
    tpick  = in1 ? t1s : t0s;
    code_pick = dv_tag.carry.code;
    if (code_pick == OUT_HIT) begin
      if (!in1 && !in0) begin
        code_pick = OUT_MISS;
      end else if (tpick >= cur_s) begin
        code_pick = OUT_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_s <= code_pick;
    ts     <= tpick[30:0];
    cs     <= dv_tag.carry;

    for (int i = 0; i < 3; i++) begin
      prod[i] <= $signed({1'b0, ts}) * $signed(cs.d[i]);
    end
    code_p <= code_s;
    tp     <= ts;
    cp     <= cs;

    for (int i = 0; i < 3; i++) begin
      hp[i] <= sat32(72'(prod[i] >>> FRAC_BITS) + 72'($signed(cp.oc[i])));
    end
    code_a <= code_p;
    ta     <= tp;
    ca     <= cp;

    for (int i = 0; i < 3; i++) begin
      pm[i] <= hp[i] * $signed(cfg.axis[i]);
    end
    code_m <= code_a;
    tm     <= ta;
    cm     <= ca;
  end

  assign mpos = sat32(72'(pm[0] >>> FRAC_BITS) + 72'(pm[1] >>> FRAC_BITS)
                      + 72'(pm[2] >>> FRAC_BITS));

  always_comb begin
    code_f = code_m;
    if (code_m == OUT_HIT && !(mpos > cm.cutl && mpos < cm.cuth)) begin
      code_f = OUT_CUT;
    end
  end

  always_ff @(posedge clk) begin
    result.hit       <= (code_f == OUT_HIT);
    result.new_dist  <= (code_f == OUT_HIT) ? tm : cm.cur;
    result.axial_pos <= (code_f == OUT_HIT || code_f == OUT_CUT) ? mpos : 32'sd0;
    result.outcome   <= code_f;
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray / finite cylinder intersection unit. Rays go
// in as bursts with random gaps between them. Each ray is scored by a bit-true
// fixed-point predictor, and every strobed result is compared field by field
// with the oldest pending prediction. The cylinder is reprogrammed between
// phases, and only while no ray is in flight.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rfci_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int    FRAC       = 16;
  localparam int    DRAIN_CYC  = 120;
  localparam wide_t INT64_MAXW = 128'sh7fffffffffffffff;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  ray_t    ray;
  logic    done;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  ray_finite_cylinder_intersect_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .ray       (ray),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Copy of the cylinder as programmed, kept as wide signed values.
  wide_t cyl_centre [3];
  wide_t cyl_axis   [3];
  wide_t cyl_rsq;

  result_t pending_results [$];
  int      mismatch_count;
  int      burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the pipe hangs.
  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic wide_t sx32(input logic signed [31:0] v);
    return v;
  endfunction

  function automatic wide_t sat_s32(input wide_t v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  // products are floored: arithmetic shift of the full product
  function automatic wide_t qmul(input wide_t x, input wide_t y);
    return (x * y) >>> FRAC;
  endfunction

  function automatic wide_t qsq(input wide_t x);
    wide_t mag;
    mag = (x < 0) ? -x : x;
    return (mag * mag) >>> FRAC;
  endfunction

  function automatic wide_t floor_sqrt(input logic [63:0] v);
    logic [63:0] rem, root, bitv;
    rem  = v;
    root = '0;
    bitv = 64'h4000000000000000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return wide_t'(root);
  endfunction

  // (num << F) / a, truncated toward zero
  function automatic wide_t root_div(input wide_t num, input wide_t a);
    wide_t q;
    q = (((num < 0) ? -num : num) <<< FRAC) / a;
    return (num < 0) ? -q : q;
  endfunction

  function automatic result_t cylinder_hit(input ray_t r);
    wide_t   d [3];
    wide_t   oc [3];
    wide_t   dd, du, od, ou, oo, a, h, c, disc, s, t0, t1, t, m, sum, hp;
    wide_t   rmin, rmax, cur;
    logic [2:0] code;
    result_t res;
    d[0]  = sx32(r.dir_x);
    d[1]  = sx32(r.dir_y);
    d[2]  = sx32(r.dir_z);
    oc[0] = sx32(r.origin_x) - cyl_centre[0];
    oc[1] = sx32(r.origin_y) - cyl_centre[1];
    oc[2] = sx32(r.origin_z) - cyl_centre[2];
    rmin  = wide_t'(r.range_min);
    rmax  = wide_t'(r.range_max);
    cur   = wide_t'(r.current_dist);
    dd = 0; du = 0; od = 0; ou = 0; oo = 0; t = 0; m = 0;
    for (int i = 0; i < 3; i++) begin
      dd += qsq(d[i]);
      du += qmul(d[i], cyl_axis[i]);
      od += qmul(d[i], oc[i]);
      ou += qmul(oc[i], cyl_axis[i]);
      oo += qsq(oc[i]);
    end
    dd = sat_s32(dd); du = sat_s32(du); od = sat_s32(od);
    ou = sat_s32(ou); oo = sat_s32(oo);
    a = sat_s32(dd - qmul(du, du));
    h = sat_s32(od - qmul(du, ou));
    c = sat_s32(oo - qmul(ou, ou) - cyl_rsq);

    if (a <= wide_t'(PARALLEL_EPS)) begin
      code = OUT_PARALLEL;
    end else begin
      disc = h * h - a * c;
      if (disc > INT64_MAXW) disc = INT64_MAXW;
      if (disc < 0) begin
        code = OUT_NO_ROOT;
      end else begin
        s  = floor_sqrt(disc[63:0]);
        t1 = root_div(-h - s, a);
        t0 = root_div(-h + s, a);
        if (t1 >= rmin && t1 <= rmax) begin
          t = t1;
          code = OUT_HIT;
        end else if (t0 >= rmin && t0 <= rmax) begin
          t = t0;
          code = OUT_HIT;
        end else begin
          code = OUT_MISS;
        end
        if (code == OUT_HIT && t >= cur) code = OUT_MISS;
        if (code == OUT_HIT) begin
          sum = 0;
          for (int i = 0; i < 3; i++) begin
            hp = sat_s32(qmul(t, d[i]) + oc[i]);
            sum += qmul(hp, cyl_axis[i]);
          end
          m = sat_s32(sum);
          if (!(m > sx32(r.cut_low) && m < sx32(r.cut_high))) code = OUT_CUT;
        end
      end
    end
    res.hit       = (code == OUT_HIT);
    res.new_dist  = (code == OUT_HIT) ? t[30:0] : r.current_dist;
    res.axial_pos = (code == OUT_HIT || code == OUT_CUT) ? m[31:0] : 32'sd0;
    res.outcome   = code;
    return res;
  endfunction

  // ------------------------------------------------------------------ checker
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(result.outcome), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (result.hit !== want.hit)
          report_mismatch("hit", 32'(result.hit), 32'(want.hit));
        if (result.new_dist !== want.new_dist)
          report_mismatch("new_dist", 32'(result.new_dist), 32'(want.new_dist));
        if (result.axial_pos !== want.axial_pos)
          report_mismatch("axial_pos", result.axial_pos, want.axial_pos);
        if (result.outcome !== want.outcome)
          report_mismatch("outcome", 32'(result.outcome), 32'(want.outcome));
      end
    end
  end

  // ------------------------------------------------------------------ drivers
  // One ray transaction. start stays high across a burst; a gap drops it.
  task automatic send_ray(input ray_t r);
    @(negedge clk);
    start <= 1'b1;
    ray   <= r;
    do @(posedge clk); while (busy);
    pending_results.push_back(cylinder_hit(r));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTRE_X:  cyl_centre[0] = sx32(val);
      REG_CENTRE_Y:  cyl_centre[1] = sx32(val);
      REG_CENTRE_Z:  cyl_centre[2] = sx32(val);
      REG_AXIS_X:    cyl_axis[0]   = wide_t'($signed(val[17:0]));
      REG_AXIS_Y:    cyl_axis[1]   = wide_t'($signed(val[17:0]));
      REG_AXIS_Z:    cyl_axis[2]   = wide_t'($signed(val[17:0]));
      REG_RADIUS_SQ: cyl_rsq       = wide_t'(val[30:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cylinder(input int cx, input int cy, input int cz,
                               input int ax, input int ay, input int az,
                               input logic [30:0] rsq);
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_CENTRE_Z, cz);
    write_reg(REG_AXIS_X, ax);
    write_reg(REG_AXIS_Y, ay);
    write_reg(REG_AXIS_Z, az);
    write_reg(REG_RADIUS_SQ, {1'b0, rsq});
  endtask

  // --------------------------------------------------------------- generators
  function automatic int span_rand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic ray_t make_ray(input int ox, input int oy, input int oz,
                                    input int dx, input int dy, input int dz);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.current_dist = 31'h7fffffff;
    r.range_min = '0;
    r.range_max = 31'h7fffffff;
    r.cut_low = 32'sh80000000;
    r.cut_high = 32'sh7fffffff;
    return r;
  endfunction

  // Mostly rays aimed near the cylinder with sane windows; some raw noise.
  function automatic ray_t random_ray();
    ray_t         r;
    int           aim;
    logic [351:0] noise;
    if ($urandom_range(0, 99) < 15) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(ray_t)-1:0];
      return r;
    end
    aim = $urandom_range(0, 2);
    r = make_ray(int'(cyl_centre[0]) + span_rand(8 << FRAC),
                 int'(cyl_centre[1]) + span_rand(8 << FRAC),
                 int'(cyl_centre[2]) + span_rand(8 << FRAC),
                 span_rand(2 << FRAC), span_rand(2 << FRAC), span_rand(2 << FRAC));
    // for two of the three aims, point the ray roughly back toward the centre on one axis
    case (aim)
      0: r.dir_x = (r.origin_x > cyl_centre[0]) ? -$urandom_range(1, 3 << FRAC)
                                                 : $urandom_range(1, 3 << FRAC);
      1: r.dir_z = (r.origin_z > cyl_centre[2]) ? -$urandom_range(1, 3 << FRAC)
                                                 : $urandom_range(1, 3 << FRAC);
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) r.current_dist = 31'($urandom_range(0, 16 << FRAC));
    if ($urandom_range(0, 3) == 0) r.range_min = 31'($urandom_range(0, 8 << FRAC));
    if ($urandom_range(0, 3) == 0) r.range_max = 31'($urandom_range(0, 16 << FRAC));
    if ($urandom_range(0, 2) == 0) begin
      r.cut_low  = span_rand(6 << FRAC);
      r.cut_high = span_rand(6 << FRAC);
    end
    return r;
  endfunction

  // -------------------------------------------------------------------- tests
  // Hand-picked rays against the reset cylinder (axis +y, radius 1.0).
  task automatic test_directed();
    ray_t r;
    localparam int ONE = 1 << FRAC;
    send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0));          // clean hit at t = 4
    send_ray(make_ray(0, 0, 0, ONE, 0, 0));                 // origin inside
    send_ray(make_ray(-5 * ONE, 0, 3 * ONE, ONE, 0, 0));    // passes beside
    send_ray(make_ray(0, 0, 0, 0, ONE, 0));                 // parallel to axis
    send_ray(make_ray(0, 0, 0, 1, ONE, 0));                 // almost parallel
    send_ray(make_ray(0, 0, 0, 0, 0, 0));                   // zero direction
    send_ray(make_ray(5 * ONE, 0, 0, ONE, 0, 0));           // roots behind
    send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, ONE / 2));    // tangent-ish
    r = make_ray(-5 * ONE, 0, 0, ONE, 0, 0);
    r.current_dist = 31'(4 * ONE);                          // not nearer
    send_ray(r);
    r.current_dist = 31'(4 * ONE + 1);                      // just nearer
    send_ray(r);
    r = make_ray(-5 * ONE, 0, 0, ONE, 0, 0);
    r.range_min = 31'(5 * ONE); r.range_max = 31'(3 * ONE); // empty range
    send_ray(r);
    r.range_min = 31'(5 * ONE); r.range_max = 31'(10 * ONE); // far root only
    send_ray(r);
    r = make_ray(-5 * ONE, 0, 0, ONE, 0, 0);
    r.cut_low = 0; r.cut_high = 0;                          // empty cut
    send_ray(r);
    r.cut_low = -1; r.cut_high = 1;                         // cut just around 0
    send_ray(r);
    r = make_ray(-5 * ONE, 2 * ONE, 0, ONE, ONE, 0);
    r.cut_low = 0; r.cut_high = 6 * ONE;                    // hit on the cut's upper edge
    send_ray(r);
    // field extremes
    r = make_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_ray(r);
    r = make_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 32'sh80000000);
    r.current_dist = '0; r.range_max = '0;
    send_ray(r);
    r = make_ray(32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000);
    send_ray(r);
    r = make_ray(-ONE, 0, -ONE, 32'sh7fffffff, 0, 32'sh7fffffff);
    send_ray(r);
    wait_idle();
  endtask

  task automatic test_random_phase(input int count);
    for (int i = 0; i < count; i++) send_ray(random_ray());
    wait_idle();
  endtask

  // Random sensible cylinders, each followed by a batch of rays.
  task automatic test_random_cylinders(input int phases, input int count);
    int ax, ay, az;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 3))
        0: begin ax = 65536; ay = 0; az = 0; end
        1: begin ax = 0; ay = 0; az = -65536; end
        2: begin ax = 46341; ay = -46341; az = 0; end
        default: begin ax = span_rand(65536); ay = span_rand(65536); az = span_rand(65536); end
      endcase
      load_cylinder(span_rand(4 << FRAC), span_rand(4 << FRAC), span_rand(4 << FRAC),
                    ax, ay, az, 31'($urandom_range(1 << 12, 9 << FRAC)));
      test_random_phase(count);
    end
  endtask

  // Register extremes: huge centres, negative unit axis, zero and max radius.
  task automatic test_cylinder_extremes();
    load_cylinder(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                  -65536, 65536, -65536, 31'h7fffffff);
    test_random_phase(60);
    load_cylinder(0, 0, 0, 0, -65536, 0, '0);
    test_random_phase(60);
    load_cylinder(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                  65536, -65536, 65536, 31'h7fffffff);
    test_random_phase(40);
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    ray        = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_CENTRE_X;
    cfg_data   = '0;
    burst_left = 0;
    mismatch_count = 0;
    cyl_centre[0] = 0; cyl_centre[1] = 0; cyl_centre[2] = 0;
    cyl_axis[0] = 0; cyl_axis[1] = 65536; cyl_axis[2] = 0;
    cyl_rsq = 65536;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_phase(200);
    test_random_cylinders(6, 180);
    test_cylinder_extremes();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
